FILE: hdl/nst_pkg.sv
// ============================================================================
// nst_pkg: shared types and constants of the named semaphore table
// command codes, the command record handed from front to back, defaults
// ============================================================================
`default_nettype none
package nst_pkg;

    localparam int SLOTS_DEF       = 8;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int KEY_BYTES_DEF   = 8;
    localparam int CMDQ_DEPTH      = 2;

    typedef enum logic [2:0] {
        K_OPEN    = 3'd0,
        K_WAIT    = 3'd1,
        K_POST    = 3'd2,
        K_CLOSE   = 3'd3,
        K_REMOVE  = 3'd4,
        K_RELEASE = 3'd5,
        K_BAD6    = 3'd6,
        K_BAD7    = 3'd7
    } t_kind;

    // command record after classification
    typedef struct packed {
        t_kind       kind;
        logic [63:0] key;
        logic [15:0] init;
        logic [2:0]  sid;
        logic [15:0] pid;
        logic [7:0]  mask;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_DRAIN,
        S_REMOVE,
        S_FINAL
    } t_state;

    // cut key to key_bytes bytes and clear everything after the first zero
    function automatic logic [63:0] norm_key(input logic [63:0] k, input int key_bytes);
        logic [63:0] r;
        logic        stop;
        r    = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (i >= key_bytes || k[8*i +: 8] == 8'd0) stop = 1'b1;
            if (!stop) r[8*i +: 8] = k[8*i +: 8];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/nst_front.sv
// ============================================================================
// nst_front: command intake
// normalizes the name key and queues commands in a short fifo for the back end
// ============================================================================
`default_nettype none
module nst_front #(
    parameter int KEY_BYTES = nst_pkg::KEY_BYTES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [2:0]    i_kind,
    input  wire logic [63:0]   i_name_key,
    input  wire logic [15:0]   i_initial_count,
    input  wire logic [2:0]    i_slot_id,
    input  wire logic [15:0]   i_proc_id,
    input  wire logic [7:0]    i_owner_mask,
    output logic               o_cmd_valid,
    input  wire logic          i_cmd_ready,
    output nst_pkg::t_cmd      o_cmd
);
    import nst_pkg::*;

    t_cmd       r_q [CMDQ_DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;

    always_comb begin
        w_cmd.kind = t_kind'(i_kind);
        w_cmd.key  = norm_key(i_name_key, KEY_BYTES);
        w_cmd.init = i_initial_count;
        w_cmd.sid  = i_slot_id;
        w_cmd.pid  = i_proc_id;
        w_cmd.mask = i_owner_mask;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // fifo storage
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) r_q[r_wp] <= w_cmd;
    end

    // fifo pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_valid && o_ready) r_wp <= ~r_wp;
            if (o_cmd_valid && i_cmd_ready) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_valid && o_ready) - 2'(o_cmd_valid && i_cmd_ready);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !o_ready) else $error("fifo overflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("fifo count bad");
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd0 |-> !o_cmd_valid) else $error("pop from empty");
`endif
endmodule
`default_nettype wire

FILE: hdl/nst_back.sv
// ============================================================================
// nst_back: command execution
// runs one command at a time over the slot table and emits result beats
// ============================================================================
`default_nettype none
module nst_back #(
    parameter int SLOTS       = nst_pkg::SLOTS_DEF,
    parameter int QUEUE_DEPTH = nst_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    output logic             o_cmd_ready,
    input  wire nst_pkg::t_cmd i_cmd,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_status,
    output logic [2:0]       o_result_id,
    output logic             o_must_block,
    output logic             o_wake_valid,
    output logic [15:0]      o_wake_pid,
    output logic             o_last
);
    import nst_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam logic signed [31:0] CMAX = 32'sh7fffffff;
    localparam logic signed [31:0] CMIN = 32'sh80000000;

    // ring index plus offset, wrapped by compare and subtract
    function automatic logic [QW-1:0] q_add(input logic [QW-1:0] a, input logic [LW-1:0] b);
        logic [LW:0] t;
        t = (LW+1)'(a) + (LW+1)'(b);
        if (32'(t) >= QUEUE_DEPTH) t = t - (LW+1)'(QUEUE_DEPTH);
        return QW'(t);
    endfunction

    // slot table
    logic                    r_used  [SLOTS];
    logic [63:0]             r_key   [SLOTS];
    logic signed [31:0]      r_count [SLOTS];
    logic [15:0]             r_refs  [SLOTS];
    logic [QW-1:0]           r_head  [SLOTS];
    logic [LW-1:0]           r_len   [SLOTS];
    logic [15:0]             r_pids  [SLOTS][QUEUE_DEPTH];

    t_state      r_state, n_state;
    t_cmd        r_cmd;
    logic [SW-1:0] r_slot;      // slot being popped, drained or scanned
    logic [7:0]  r_pend;        // slots still to close in release
    logic        r_fst;         // final status
    logic [2:0]  r_frid;
    logic        r_fblk;

    // output register
    logic        r_ov;
    logic        r_st, r_blk, r_wv, r_lst;
    logic [2:0]  r_rid;
    logic [15:0] r_wpid;

    assign o_valid      = r_ov;
    assign o_status     = r_st;
    assign o_result_id  = r_rid;
    assign o_must_block = r_blk;
    assign o_wake_valid = r_wv;
    assign o_wake_pid   = r_wpid;
    assign o_last       = r_lst;

    logic w_oslot;
    assign w_oslot     = !r_ov || i_ready;
    assign o_cmd_ready = (r_state == S_IDLE);

    // open lookup
    logic          w_hit, w_free;
    logic [SW-1:0] w_hidx, w_fidx;
    always_comb begin
        w_hit = 1'b0; w_free = 1'b0; w_hidx = '0; w_fidx = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (r_used[s] && r_key[s] == r_cmd.key) begin
                w_hit = 1'b1; w_hidx = SW'(s);
            end
            if (!r_used[s]) begin
                w_free = 1'b1; w_fidx = SW'(s);
            end
        end
    end

    // next pending release slot
    logic          w_pany;
    logic [SW-1:0] w_pidx;
    always_comb begin
        w_pany = 1'b0; w_pidx = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (s < 8 && r_pend[s]) begin
                w_pany = 1'b1; w_pidx = SW'(s);
            end
        end
    end

    logic w_sok;
    assign w_sok = (32'(r_cmd.sid) < SLOTS) && r_used[SW'(r_cmd.sid)];
    logic [SW-1:0] w_sid;
    assign w_sid = SW'(r_cmd.sid);

    // saturated value after wait and after post
    logic signed [31:0] w_cdec, w_cinc;
    assign w_cdec = (r_count[w_sid] != CMIN) ? r_count[w_sid] - 32'sd1 : CMIN;
    assign w_cinc = (r_count[w_sid] != CMAX) ? r_count[w_sid] + 32'sd1 : CMAX;

    // killed pid compaction for the scanned slot
    logic          w_found;
    logic [15:0]   w_cmp [QUEUE_DEPTH];
    logic [LW-1:0] w_m;
    always_comb begin
        logic [QW-1:0] idx;
        w_found = 1'b0; w_m = '0; idx = r_head[r_slot];
        for (int i = 0; i < QUEUE_DEPTH; i++) w_cmp[i] = r_pids[r_slot][i];
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (LW'(i) < r_len[r_slot]) begin
                if (r_pids[r_slot][idx] == r_cmd.pid && !w_found) w_found = 1'b1;
                else begin
                    w_cmp[w_m[QW-1:0]] = r_pids[r_slot][idx];
                    w_m = w_m + 1'b1;
                end
                idx = q_add(idx, LW'(1));
            end
        end
    end

    logic [15:0] w_hpid;
    assign w_hpid = r_pids[r_slot][r_head[r_slot]];

    // freed slot with waiters left to pop
    logic w_dpop;
    assign w_dpop = !r_used[r_slot] && r_len[r_slot] != '0;

    // beat loads into the output register
    logic w_fin, w_wake;
    assign w_fin  = (r_state == S_FINAL) && w_oslot;
    assign w_wake = w_oslot && (w_hpid != 16'd0) &&
                    ((r_state == S_POP) || (r_state == S_DRAIN && w_dpop));

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_cmd_valid) n_state = S_EXEC;
            S_EXEC: begin
                case (r_cmd.kind)
                    K_CLOSE:   n_state = w_sok ? S_DRAIN : S_FINAL;
                    K_POST:    n_state = (w_sok && w_cinc <= 0 && r_len[w_sid] != '0) ?
                                         S_POP : S_FINAL;
                    K_REMOVE:  n_state = S_REMOVE;
                    K_RELEASE: n_state = S_DRAIN;
                    default:   n_state = S_FINAL;
                endcase
            end
            S_POP:    if (w_oslot) n_state = S_FINAL;
            S_DRAIN:  if (w_oslot && !w_dpop && !w_pany) n_state = S_FINAL;
            S_REMOVE: if (32'(r_slot) == SLOTS - 1) n_state = S_FINAL;
            S_FINAL:  if (w_oslot) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_fin || w_wake) begin
            r_ov   <= 1'b1;
            r_st   <= w_fin && r_fst;
            r_rid  <= w_fin ? r_frid : 3'd0;
            r_blk  <= w_fin && r_fblk;
            r_wv   <= w_wake;
            r_wpid <= w_wake ? w_hpid : 16'd0;
            r_lst  <= w_fin;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                r_used[s] <= 1'b0; r_count[s] <= '0; r_refs[s] <= '0;
                r_head[s] <= '0;   r_len[s] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) r_cmd <= i_cmd;
                    r_fst <= 1'b0; r_frid <= '0; r_fblk <= 1'b0;
                    r_slot <= '0; r_pend <= '0;
                end
                S_EXEC: begin
                    case (r_cmd.kind)
                        K_OPEN: begin
                            if (w_hit) begin
                                if (r_refs[w_hidx] != 16'hffff)
                                    r_refs[w_hidx] <= r_refs[w_hidx] + 1'b1;
                                r_frid <= 3'(w_hidx);
                            end else if (w_free) begin
                                r_used[w_fidx] <= 1'b1; r_key[w_fidx] <= r_cmd.key;
                                r_count[w_fidx] <= 32'(r_cmd.init);
                                r_refs[w_fidx] <= 16'd1;
                                r_head[w_fidx] <= '0; r_len[w_fidx] <= '0;
                                r_frid <= 3'(w_fidx);
                            end else r_fst <= 1'b1;
                        end
                        K_WAIT: begin
                            if (!w_sok) r_fst <= 1'b1;
                            else begin
                                r_count[w_sid] <= w_cdec;
                                if (w_cdec < 0) begin
                                    r_fblk <= 1'b1;
                                    if (32'(r_len[w_sid]) < QUEUE_DEPTH) begin
                                        r_pids[w_sid][q_add(r_head[w_sid], r_len[w_sid])]
                                            <= r_cmd.pid;
                                        r_len[w_sid] <= r_len[w_sid] + 1'b1;
                                    end
                                end
                            end
                        end
                        K_POST: begin
                            if (!w_sok) r_fst <= 1'b1;
                            else begin
                                r_count[w_sid] <= w_cinc;
                                r_slot <= w_sid;
                            end
                        end
                        K_CLOSE: begin
                            if (!w_sok) r_fst <= 1'b1;
                            else begin
                                r_slot <= w_sid;
                                if (r_refs[w_sid] <= 16'd1) begin
                                    r_refs[w_sid] <= '0; r_used[w_sid] <= 1'b0;
                                end else begin
                                    r_refs[w_sid] <= r_refs[w_sid] - 1'b1;
                                end
                            end
                        end
                        K_RELEASE: begin
                            r_pend <= r_cmd.mask;
                        end
                        K_REMOVE: r_slot <= '0;
                        default: r_fst <= 1'b1;
                    endcase
                end
                S_POP: begin
                    // one waiter leaves the head of the posted slot
                    if (w_oslot) begin
                        r_head[r_slot] <= q_add(r_head[r_slot], LW'(1));
                        r_len[r_slot]  <= r_len[r_slot] - 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (w_oslot) begin
                        if (w_dpop) begin
                            // pop one waiter of a freed slot
                            r_head[r_slot] <= (r_len[r_slot] == LW'(1)) ? '0 :
                                              q_add(r_head[r_slot], LW'(1));
                            r_len[r_slot]  <= r_len[r_slot] - 1'b1;
                        end else if (w_pany) begin
                            // drop one reference of the next masked slot
                            r_pend[w_pidx] <= 1'b0;
                            r_slot <= w_pidx;
                            if (r_used[w_pidx]) begin
                                if (r_refs[w_pidx] <= 16'd1) begin
                                    r_refs[w_pidx] <= '0; r_used[w_pidx] <= 1'b0;
                                end else r_refs[w_pidx] <= r_refs[w_pidx] - 1'b1;
                            end
                        end
                    end
                end
                S_REMOVE: begin
                    if (r_used[r_slot] && r_len[r_slot] != '0 && w_found) begin
                        for (int i = 0; i < QUEUE_DEPTH; i++) r_pids[r_slot][i] <= w_cmp[i];
                        r_head[r_slot] <= '0;
                        r_len[r_slot]  <= w_m;
                        if (r_count[r_slot] != CMAX) r_count[r_slot] <= r_count[r_slot] + 1;
                    end
                    if (32'(r_slot) != SLOTS - 1) r_slot <= r_slot + 1'b1;
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_last_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !o_wake_valid) else $error("final beat carries wake");
    a_wake_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_wake_valid |-> o_wake_pid != 16'd0) else $error("wake of pid zero");
    a_idle_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_ready |-> r_state == S_IDLE) else $error("took command while busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("beat lost");
`endif
endmodule
`default_nettype wire

FILE: hdl/named_semaphore_table_core.sv
// Flow: a command passes the intake fifo, then the back end's execute and final states;
// a post that pops a waiter passes the pop state, close drains the queued pids of a freed slot,
// release drops one reference per set mask bit and drains queued pids of freed slots; a
// waiter purge scans every slot. The back end runs one command at a time; output stalls hold it.
// Reset: synchronous active-low clears slot flags, counts, refs and queue pointers;
// name keys and queued pids are not cleared and are read only after being written.
// ============================================================================
// named_semaphore_table_core: hardware named counting semaphore table
// front intake fifo feeding a sequential execution back end
// ============================================================================
`default_nettype none
module named_semaphore_table_core #(
    parameter int SLOTS       = nst_pkg::SLOTS_DEF,
    parameter int QUEUE_DEPTH = nst_pkg::QUEUE_DEPTH_DEF,
    parameter int KEY_BYTES   = nst_pkg::KEY_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_kind,
    input  wire logic [63:0] i_name_key,
    input  wire logic [15:0] i_initial_count,
    input  wire logic [2:0]  i_slot_id,
    input  wire logic [15:0] i_proc_id,
    input  wire logic [7:0]  i_owner_mask,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_status,
    output logic [2:0]       o_result_id,
    output logic             o_must_block,
    output logic             o_wake_valid,
    output logic [15:0]      o_wake_pid,
    output logic             o_last
);
    import nst_pkg::*;

    logic w_cv, w_cr;
    t_cmd w_cmd;

    // command intake
    nst_front #(.KEY_BYTES(KEY_BYTES)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_kind, .i_name_key,
        .i_initial_count, .i_slot_id, .i_proc_id, .i_owner_mask,
        .o_cmd_valid(w_cv), .i_cmd_ready(w_cr), .o_cmd(w_cmd)
    );

    // execution
    nst_back #(.SLOTS(SLOTS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(w_cv), .o_cmd_ready(w_cr), .i_cmd(w_cmd),
        .o_valid, .i_ready, .o_status, .o_result_id, .o_must_block,
        .o_wake_valid, .o_wake_pid, .o_last
    );
endmodule
`default_nettype wire
